// ----- hdl/icmp_per_subnet_rate_filter_defines.svh -----
// Assertion macros for the ICMP per-subnet rate filter.
`ifndef ICMP_PER_SUBNET_RATE_FILTER_DEFINES_SVH
`define ICMP_PER_SUBNET_RATE_FILTER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define IPSRF_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IPSRF_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ----- hdl/ipsrf_pkg.sv -----
// Package with types and constants of the ICMP per-subnet rate filter.
`timescale 1ns / 1ps
`default_nettype none
package ipsrf_pkg;
  localparam int TABLE_ENTRIES = 2048;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [31:0] SUBNET_MASK = 32'hFFFF_FF00;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0] TYPE_UNREACH = 8'd3;
  localparam logic [7:0] TYPE_REDIRECT = 8'd5;
  localparam logic [7:0] CODE_FRAG_NEEDED = 8'd4;
  localparam logic [1:0] REG_SUBNET_SALT = 2'd0;
  localparam logic [1:0] REG_CREDIT_LIMIT = 2'd1;
  localparam logic [1:0] REG_REFILL_AMOUNT = 2'd2;
  localparam logic [1:0] REG_REFILL_INTERVAL = 2'd3;
  localparam logic [1:0] REASON_NONE = 2'd0;
  localparam logic [1:0] REASON_RATE = 2'd1;
  localparam logic [1:0] REASON_REDIRECT = 2'd2;
  localparam logic [1:0] REASON_FRAG = 2'd3;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_WRITE
  } bk_state_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [7:0] icmp_type;
    logic [7:0] icmp_code;
    logic inner_ip_ok;
    logic [7:0] inner_protocol;
    logic inner_icmp_ok;
    logic [7:0] inner_icmp_type;
    logic [63:0] now_ns;
    logic [1:0] cost;
  } in_word_t;

  typedef struct packed {
    logic policed;
    logic [IDX_W-1:0] idx;
    logic is_redirect;
    logic post_check;
    logic redirect_bad;
    logic frag_bad;
    logic [63:0] now_ns;
    logic [1:0] cost;
  } job_t;

  typedef struct packed {
    logic verdict;
    logic [1:0] drop_reason;
    logic [10:0] bucket_index;
    logic [9:0] credit_after;
  } out_word_t;

  typedef struct packed {
    logic [31:0] subnet_salt;
    logic [9:0] credit_limit;
    logic [9:0] refill_amount;
    logic [29:0] refill_interval_ns;
  } cfg_regs_t;
endpackage
`default_nettype wire

// ----- hdl/ipsrf_if.sv -----
// Valid/ready channel interfaces of the ICMP per-subnet rate filter.
`timescale 1ns / 1ps
`default_nettype none
interface ipsrf_in_if import ipsrf_pkg::*; ();
  logic valid;
  logic ready;
  logic ipv4_header_ok;
  logic [7:0] ip_protocol;
  logic icmp_header_ok;
  logic [31:0] source_address;
  logic [7:0] icmp_type;
  logic [7:0] icmp_code;
  logic inner_ip_ok;
  logic [7:0] inner_protocol;
  logic inner_icmp_ok;
  logic [7:0] inner_icmp_type;
  logic [63:0] now_ns;
  logic [1:0] cost;
  modport source (output valid, ipv4_header_ok, ip_protocol, icmp_header_ok,
    source_address, icmp_type, icmp_code, inner_ip_ok, inner_protocol,
    inner_icmp_ok, inner_icmp_type, now_ns, cost, input ready);
  modport sink (input valid, ipv4_header_ok, ip_protocol, icmp_header_ok,
    source_address, icmp_type, icmp_code, inner_ip_ok, inner_protocol,
    inner_icmp_ok, inner_icmp_type, now_ns, cost, output ready);
endinterface

interface ipsrf_out_if ();
  logic valid;
  logic ready;
  logic verdict;
  logic [1:0] drop_reason;
  logic [10:0] bucket_index;
  logic [9:0] credit_after;
  modport source (output valid, verdict, drop_reason, bucket_index,
    credit_after, input ready);
  modport sink (input valid, verdict, drop_reason, bucket_index,
    credit_after, output ready);
endinterface

interface ipsrf_cfg_if ();
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ipsrf_front.sv -----
// Front end: classifies packets and computes bucket index and post checks.
`timescale 1ns / 1ps
`default_nettype none
module ipsrf_front import ipsrf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  ipsrf_in_if.sink in_ch,
  input wire logic [31:0] subnet_salt,
  output job_t job,
  output logic job_valid,
  input wire logic job_ready
);
  job_t job_r, job_nxt;
  logic job_valid_r;
  logic [31:0] hashed;
  logic is_frag;

  assign in_ch.ready = !job_valid_r || job_ready;
  assign hashed = (in_ch.source_address & SUBNET_MASK) ^ subnet_salt;
  assign is_frag = (in_ch.icmp_type == TYPE_UNREACH) &&
                   (in_ch.icmp_code == CODE_FRAG_NEEDED);

  always_comb begin
    job_nxt.policed = in_ch.ipv4_header_ok && (in_ch.ip_protocol == PROTO_ICMP)
                      && in_ch.icmp_header_ok;
    job_nxt.idx = hashed[IDX_W-1:0];
    job_nxt.is_redirect = (in_ch.icmp_type == TYPE_REDIRECT);
    job_nxt.post_check = (is_frag || job_nxt.is_redirect) && in_ch.inner_ip_ok;
    job_nxt.redirect_bad = (in_ch.inner_protocol == PROTO_UDP) ||
                           (in_ch.inner_protocol == PROTO_ICMP);
    job_nxt.frag_bad = (in_ch.inner_protocol == PROTO_ICMP) && in_ch.inner_icmp_ok
      && ((in_ch.inner_icmp_type == TYPE_ECHO_REPLY) ||
          (in_ch.inner_icmp_type == TYPE_UNREACH) ||
          (in_ch.inner_icmp_type == TYPE_REDIRECT));
    job_nxt.now_ns = in_ch.now_ns;
    job_nxt.cost = in_ch.cost;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      job_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      job_r <= job_nxt;
    end
  end

  assign job = job_r;
  assign job_valid = job_valid_r;
endmodule
`default_nettype wire

// ----- hdl/ipsrf_back.sv -----
// Back end: bucket memory read-modify-write and result register.
`timescale 1ns / 1ps
`default_nettype none
module ipsrf_back import ipsrf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input job_t job,
  input wire logic job_valid,
  output logic job_ready,
  input cfg_regs_t cfg,
  ipsrf_out_if.source out_ch
);
  bk_state_t state_r, state_nxt;
  job_t cur_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic valid_mem [TABLE_ENTRIES];
  logic [9:0] credit_mem [TABLE_ENTRIES];
  logic [29:0] accum_mem [TABLE_ENTRIES];
  logic [63:0] stamp_mem [TABLE_ENTRIES];
  logic [9:0] rd_credit_r;
  logic [29:0] rd_accum_r;
  logic [63:0] rd_stamp_r;
  logic fresh_r;
  logic [9:0] wr_credit_r;
  logic [29:0] wr_accum_r;
  out_word_t res_r, res_nxt;
  logic res_valid_r;
  logic take, do_clear, do_read, do_calc, do_write;
  logic [9:0] c0;
  logic [29:0] a0;
  logic [63:0] s0, elapsed;
  logic [30:0] cap;
  logic [31:0] accum;
  logic [31:0] acc_sub;
  logic [10:0] credit_sum;
  logic [9:0] credit_ref;
  logic [29:0] accum_new;

  assign job_ready = (state_r == BK_IDLE) && !res_valid_r;
  assign take = job_ready && job_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) state_nxt = BK_IDLE;
      BK_IDLE: if (take && job.policed) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_CALC;
      BK_CALC: state_nxt = BK_WRITE;
      BK_WRITE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    do_clear = (state_r == BK_CLEAR);
    do_read = (state_r == BK_READ);
    do_calc = (state_r == BK_CALC);
    do_write = (state_r == BK_WRITE);
  end

  always_comb begin
    c0 = fresh_r ? cfg.credit_limit : rd_credit_r;
    a0 = fresh_r ? 30'd0 : rd_accum_r;
    s0 = fresh_r ? cur_r.now_ns : rd_stamp_r;
    elapsed = cur_r.now_ns - s0;
    cap = {cfg.refill_interval_ns, 1'b0};
    if (elapsed > {33'd0, cap}) elapsed = {33'd0, cap};
    accum = {2'b00, a0} + elapsed[31:0];
    credit_ref = c0;
    accum_new = accum[29:0];
    acc_sub = accum - {2'b00, cfg.refill_interval_ns};
    credit_sum = {1'b0, c0} + {1'b0, cfg.refill_amount};
    if (accum >= {2'b00, cfg.refill_interval_ns}) begin
      accum_new = (acc_sub > {2'b00, cfg.refill_interval_ns}) ?
                  cfg.refill_interval_ns : acc_sub[29:0];
      credit_ref = (credit_sum > {1'b0, cfg.credit_limit}) ?
                   cfg.credit_limit : credit_sum[9:0];
    end
  end

  always_comb begin
    res_nxt = '0;
    if (take && !job.policed) begin
      res_nxt = '0;
    end else begin
      res_nxt.bucket_index = 11'(cur_r.idx);
      if (credit_ref < {8'd0, cur_r.cost}) begin
        res_nxt.verdict = 1'b1;
        res_nxt.drop_reason = REASON_RATE;
        res_nxt.credit_after = credit_ref;
      end else begin
        res_nxt.credit_after = credit_ref - {8'd0, cur_r.cost};
        if (cur_r.post_check && cur_r.is_redirect && cur_r.redirect_bad) begin
          res_nxt.verdict = 1'b1;
          res_nxt.drop_reason = REASON_REDIRECT;
        end else if (cur_r.post_check && !cur_r.is_redirect && cur_r.frag_bad) begin
          res_nxt.verdict = 1'b1;
          res_nxt.drop_reason = REASON_FRAG;
        end else begin
          res_nxt.drop_reason = REASON_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_idx_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_clear) clr_idx_r <= clr_idx_r + 1'b1;
      if ((take && !job.policed) || do_calc) begin
        res_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
    end
    if (take) cur_r <= job;
    if (do_read) begin
      rd_credit_r <= credit_mem[cur_r.idx];
      rd_accum_r <= accum_mem[cur_r.idx];
      rd_stamp_r <= stamp_mem[cur_r.idx];
      fresh_r <= !valid_mem[cur_r.idx];
    end
    if ((take && !job.policed) || do_calc) res_r <= res_nxt;
    if (do_calc) begin
      wr_credit_r <= res_nxt.credit_after;
      wr_accum_r <= accum_new;
    end
    if (do_clear) valid_mem[clr_idx_r] <= 1'b0;
    if (do_write) begin
      valid_mem[cur_r.idx] <= 1'b1;
      credit_mem[cur_r.idx] <= wr_credit_r;
      accum_mem[cur_r.idx] <= wr_accum_r;
      stamp_mem[cur_r.idx] <= cur_r.now_ns;
    end
  end

  assign out_ch.valid = res_valid_r;
  assign out_ch.verdict = res_r.verdict;
  assign out_ch.drop_reason = res_r.drop_reason;
  assign out_ch.bucket_index = res_r.bucket_index;
  assign out_ch.credit_after = res_r.credit_after;
endmodule
`default_nettype wire

// ----- hdl/ipsrf_cfg.sv -----
// Configuration register file of the ICMP per-subnet rate filter.
`timescale 1ns / 1ps
`default_nettype none
module ipsrf_cfg import ipsrf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  ipsrf_cfg_if.sink cfg_ch,
  output cfg_regs_t regs
);
  cfg_regs_t regs_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.subnet_salt <= '0;
      regs_r.credit_limit <= 10'd1000;
      regs_r.refill_amount <= 10'd500;
      regs_r.refill_interval_ns <= 30'd500000000;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SUBNET_SALT: regs_r.subnet_salt <= cfg_ch.data;
        REG_CREDIT_LIMIT: regs_r.credit_limit <= cfg_ch.data[9:0];
        REG_REFILL_AMOUNT: regs_r.refill_amount <= cfg_ch.data[9:0];
        REG_REFILL_INTERVAL: regs_r.refill_interval_ns <= cfg_ch.data[29:0];
        default: regs_r <= regs_r;
      endcase
    end
  end

  assign regs = regs_r;
endmodule
`default_nettype wire

// ----- hdl/icmp_per_subnet_rate_filter.sv -----
// Top level of the ICMP per-subnet rate filter.
// The in channel takes one word of parsed header fields per packet; the out
// channel returns one verdict word per packet, in order. The cfg channel
// writes registers by index and is always ready; write it only when idle.
// A front stage classifies the packet and hashes the source /24 to a bucket.
// A one-entry queue register separates it from the back end, which does a
// read-modify-write of the bucket memory.
// Unpoliced packets yield a result in the cycle after leaving the queue; the
// back end takes no new packet while a result waits on the out channel. A
// policed packet passes the back end in four steps (take, read, compute,
// write), and the memory update must end before the next packet is taken.
// After reset a clearing pass over all 2048 entries zeroes the bucket valid
// bits; the back end accepts nothing until it ends.
// When the receiver stalls, the result register holds and the back end and
// then the front stage stop accepting.
`timescale 1ns / 1ps
`default_nettype none
module icmp_per_subnet_rate_filter import ipsrf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  ipsrf_in_if.sink in_ch,
  ipsrf_out_if.source out_ch,
  ipsrf_cfg_if.sink cfg_ch
);
  cfg_regs_t regs;
  job_t job;
  logic job_valid, job_ready;

  ipsrf_cfg u_cfg (.clk, .rst_n, .cfg_ch, .regs);
  ipsrf_front u_front (.clk, .rst_n, .in_ch, .subnet_salt(regs.subnet_salt), .job,
    .job_valid, .job_ready);
  ipsrf_back u_back (.clk, .rst_n, .job, .job_valid, .job_ready, .cfg(regs),
    .out_ch);
endmodule
`default_nettype wire

// ----- hdl/ipsrf_checker.sv -----
// Port checker of the ICMP per-subnet rate filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "icmp_per_subnet_rate_filter_defines.svh"
module ipsrf_checker import ipsrf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic verdict,
  input wire logic [1:0] drop_reason,
  input wire logic [10:0] bucket_index,
  input wire logic [9:0] credit_after
);
  logic [23:0] out_word;

  assign out_word = {verdict, drop_reason, bucket_index, credit_after};

  `IPSRF_ASSERT_IMP(a_reason_verdict, clk, rst_n, out_valid, ((drop_reason != REASON_NONE) == verdict))
  `IPSRF_ASSERT_NXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)
  `IPSRF_ASSERT_NXT(a_hold_word, clk, rst_n, out_valid && !out_ready, $stable(out_word))
endmodule

bind icmp_per_subnet_rate_filter ipsrf_checker u_checker (.clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .verdict(out_ch.verdict),
  .drop_reason(out_ch.drop_reason), .bucket_index(out_ch.bucket_index),
  .credit_after(out_ch.credit_after));
`default_nettype wire

// ----- tb/tb_icmp_per_subnet_rate_filter.sv -----
// Testbench for the ICMP per-subnet rate filter: random and directed packets checked against a predictor.
`timescale 1ns / 1ps
module tb_icmp_per_subnet_rate_filter;
  import ipsrf_pkg::*;

  typedef struct {
    logic ipv4_ok;
    logic [7:0] proto;
    logic icmp_ok;
    logic [31:0] src;
    logic [7:0] itype;
    logic [7:0] icode;
    logic inner_ip;
    logic [7:0] inner_proto;
    logic inner_icmp;
    logic [7:0] inner_type;
    logic [63:0] now;
    logic [1:0] cost;
  } packet_t;

  class verdict_board;
    logic [31:0] key = 0;
    logic [9:0] limit = 10'd1000;
    logic [9:0] amount = 10'd500;
    logic [29:0] interval = 30'd500000000;
    bit seen [TABLE_ENTRIES];
    logic [9:0] credit [TABLE_ENTRIES];
    logic [29:0] accum [TABLE_ENTRIES];
    logic [63:0] stamp [TABLE_ENTRIES];
    out_word_t verdicts [$];
    int errors = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SUBNET_SALT: key = val;
        REG_CREDIT_LIMIT: limit = val[9:0];
        REG_REFILL_AMOUNT: amount = val[9:0];
        REG_REFILL_INTERVAL: interval = val[29:0];
        default: ;
      endcase
    endfunction

    function void note_packet(packet_t p);
      out_word_t r;
      logic [10:0] b;
      logic [64:0] el, cap, acc;
      logic [10:0] c;
      r = '0;
      if (p.ipv4_ok && p.proto == PROTO_ICMP && p.icmp_ok) begin
        b = 11'(((p.src & SUBNET_MASK) ^ key) % TABLE_ENTRIES);
        if (!seen[b]) begin
          seen[b] = 1;
          credit[b] = limit;
          accum[b] = 30'd0;
          stamp[b] = p.now;
        end
        cap = {35'd0, interval} << 1;
        el = {1'b0, p.now - stamp[b]};
        if (el > cap) el = cap;
        stamp[b] = p.now;
        acc = {35'd0, accum[b]} + el;
        c = {1'b0, credit[b]};
        if (acc >= {35'd0, interval}) begin
          acc = acc - {35'd0, interval};
          if (acc > {35'd0, interval}) acc = {35'd0, interval};
          c = c + {1'b0, amount};
          if (c > {1'b0, limit}) c = {1'b0, limit};
        end
        accum[b] = acc[29:0];
        r.bucket_index = b;
        if (c < {9'd0, p.cost}) begin
          r.verdict = 1;
          r.drop_reason = REASON_RATE;
        end else begin
          c = c - {9'd0, p.cost};
          if (((p.itype == TYPE_UNREACH && p.icode == CODE_FRAG_NEEDED) ||
               p.itype == TYPE_REDIRECT) && p.inner_ip) begin
            if (p.itype == TYPE_REDIRECT) begin
              if (p.inner_proto == PROTO_UDP || p.inner_proto == PROTO_ICMP) begin
                r.verdict = 1;
                r.drop_reason = REASON_REDIRECT;
              end
            end else if (p.inner_proto == PROTO_ICMP && p.inner_icmp &&
                         (p.inner_type == TYPE_ECHO_REPLY || p.inner_type == TYPE_UNREACH ||
                          p.inner_type == TYPE_REDIRECT)) begin
              r.verdict = 1;
              r.drop_reason = REASON_FRAG;
            end
          end
        end
        credit[b] = c[9:0];
        r.credit_after = c[9:0];
      end
      verdicts.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_verdict(out_word_t got);
      out_word_t w;
      if (verdicts.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      w = verdicts.pop_front();
      if (got.verdict !== w.verdict) report("verdict", got.verdict, w.verdict);
      if (got.drop_reason !== w.drop_reason)
        report("drop_reason", got.drop_reason, w.drop_reason);
      if (got.bucket_index !== w.bucket_index)
        report("bucket_index", got.bucket_index, w.bucket_index);
      if (got.credit_after !== w.credit_after)
        report("credit_after", got.credit_after, w.credit_after);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  ipsrf_in_if in_ch ();
  ipsrf_out_if out_ch ();
  ipsrf_cfg_if cfg_ch ();
  verdict_board board = new();
  int send_idle = 23;
  int recv_idle = 65;
  logic [63:0] clock_ns = 64'd1000;
  logic [31:0] subnets [8];

  always #6 clk = ~clk;

  icmp_per_subnet_rate_filter DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch));

  initial begin
    in_ch.valid = 0;
    {in_ch.ipv4_header_ok, in_ch.ip_protocol, in_ch.icmp_header_ok, in_ch.source_address,
     in_ch.icmp_type, in_ch.icmp_code, in_ch.inner_ip_ok, in_ch.inner_protocol,
     in_ch.inner_icmp_ok, in_ch.inner_icmp_type, in_ch.now_ns, in_ch.cost} = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_SUBNET_SALT;
    cfg_ch.data = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_verdict({out_ch.verdict, out_ch.drop_reason, out_ch.bucket_index,
                             out_ch.credit_after});
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, val);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send(packet_t p);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.ipv4_header_ok, in_ch.ip_protocol, in_ch.icmp_header_ok, in_ch.source_address,
     in_ch.icmp_type, in_ch.icmp_code, in_ch.inner_ip_ok, in_ch.inner_protocol,
     in_ch.inner_icmp_ok, in_ch.inner_icmp_type, in_ch.now_ns, in_ch.cost} <=
      {p.ipv4_ok, p.proto, p.icmp_ok, p.src, p.itype, p.icode, p.inner_ip, p.inner_proto,
       p.inner_icmp, p.inner_type, p.now, p.cost};
    do @(posedge clk); while (!in_ch.ready);
    board.note_packet(p);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic packet_t icmp_packet(logic [31:0] src, logic [7:0] t, logic [7:0] c);
    packet_t p;
    p = '{1, PROTO_ICMP, 1, src, t, c, 1, PROTO_UDP, 1, TYPE_ECHO_REPLY, 0, 1};
    p.now = clock_ns;
    return p;
  endfunction

  function automatic packet_t random_packet(logic [29:0] iv);
    packet_t p;
    int sel;
    sel = $urandom_range(99);
    clock_ns = clock_ns + ($urandom_range(3) == 0 ? $urandom_range(3 * iv) :
                           $urandom_range(iv / 4 + 1));
    p.ipv4_ok = ($urandom_range(19) != 0);
    p.proto = ($urandom_range(9) == 0) ? 8'($urandom) : PROTO_ICMP;
    p.icmp_ok = ($urandom_range(19) != 0);
    p.src = ($urandom_range(3) == 0) ? $urandom : (subnets[$urandom_range(7)] | 8'($urandom));
    p.itype = (sel < 30) ? TYPE_REDIRECT : (sel < 60) ? TYPE_UNREACH :
              (sel < 80) ? 8'($urandom) : TYPE_ECHO_REPLY;
    p.icode = ($urandom_range(2) == 0) ? 8'($urandom) : CODE_FRAG_NEEDED;
    p.inner_ip = $urandom_range(4) != 0;
    sel = $urandom_range(3);
    p.inner_proto = (sel == 0) ? PROTO_UDP : (sel == 1) ? PROTO_ICMP : 8'($urandom);
    p.inner_icmp = $urandom_range(4) != 0;
    sel = $urandom_range(4);
    p.inner_type = (sel == 0) ? TYPE_ECHO_REPLY : (sel == 1) ? TYPE_UNREACH :
                   (sel == 2) ? TYPE_REDIRECT : 8'($urandom);
    p.now = ($urandom_range(49) == 0) ? {$urandom, $urandom} : clock_ns;
    p.cost = 2'($urandom_range(3));
    return p;
  endfunction

  initial begin
    packet_t p;
    logic [29:0] iv;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 8; i++) subnets[i] = $urandom & SUBNET_MASK;

    // Directed: non-policed, extremes, post checks, backwards time, zero cost.
    p = icmp_packet(32'hFFFF_FFFF, TYPE_ECHO_REPLY, 0);
    p.ipv4_ok = 0;
    send(p);
    p = icmp_packet(32'h0, TYPE_ECHO_REPLY, 0);
    p.proto = 8'hFF;
    send(p);
    p = icmp_packet(32'h0, TYPE_ECHO_REPLY, 0);
    p.icmp_ok = 0;
    send(p);
    send(icmp_packet(32'h0A00_0001, TYPE_ECHO_REPLY, 0));
    send(icmp_packet(32'hFFFF_FFFF, TYPE_REDIRECT, 8'hFF));
    p = icmp_packet(32'hFFFF_FF01, TYPE_REDIRECT, 0);
    p.inner_proto = PROTO_ICMP;
    send(p);
    p.inner_proto = 8'd6;
    send(p);
    p.inner_ip = 0;
    p.inner_proto = PROTO_UDP;
    send(p);
    p = icmp_packet(32'h0A00_0002, TYPE_UNREACH, CODE_FRAG_NEEDED);
    p.inner_proto = PROTO_ICMP;
    send(p);
    p.inner_type = TYPE_UNREACH;
    send(p);
    p.inner_type = TYPE_REDIRECT;
    send(p);
    p.inner_type = 8'hFF;
    send(p);
    p.inner_type = TYPE_ECHO_REPLY;
    p.inner_icmp = 0;
    send(p);
    p.cost = 0;
    send(p);
    p.cost = 3;
    p.now = 0;
    send(p);
    p.now = 64'hFFFF_FFFF_FFFF_FFFF;
    send(p);
    drain();

    write_reg(REG_SUBNET_SALT, 32'hFFFF_FFFF);
    write_reg(REG_CREDIT_LIMIT, 10'd1023);
    write_reg(REG_REFILL_AMOUNT, 10'd1023);
    write_reg(REG_REFILL_INTERVAL, 30'h3FFF_FFFF);
    for (int i = 0; i < 6; i++) send(icmp_packet(32'h0A00_0003, TYPE_ECHO_REPLY, 0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SUBNET_SALT, $urandom);
          write_reg(REG_CREDIT_LIMIT, 10'd5);
          write_reg(REG_REFILL_AMOUNT, 10'd1);
          write_reg(REG_REFILL_INTERVAL, 30'd1000);
        end
        1: begin
          write_reg(REG_CREDIT_LIMIT, 10'd1);
          write_reg(REG_REFILL_AMOUNT, 10'd1023);
          write_reg(REG_REFILL_INTERVAL, 30'd1);
        end
        2: begin
          write_reg(REG_SUBNET_SALT, 0);
          write_reg(REG_CREDIT_LIMIT, 10'd1023);
          write_reg(REG_REFILL_AMOUNT, 10'd3);
          write_reg(REG_REFILL_INTERVAL, 30'd0);
        end
        3: begin
          send_idle = 65;
          recv_idle = 23;
          write_reg(REG_CREDIT_LIMIT, 10'd12);
          write_reg(REG_REFILL_AMOUNT, 10'd4);
          write_reg(REG_REFILL_INTERVAL, 30'd5000);
        end
        4: begin
          write_reg(REG_CREDIT_LIMIT, 10'd3);
          write_reg(REG_REFILL_INTERVAL, 30'h3FFF_FFFF);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_reg(REG_SUBNET_SALT, $urandom);
          write_reg(REG_CREDIT_LIMIT, 10'd8);
          write_reg(REG_REFILL_AMOUNT, 10'd2);
          write_reg(REG_REFILL_INTERVAL, 30'd2000);
        end
      endcase
      iv = board.interval;
      for (int i = 0; i < 280; i++) send(random_packet(iv));
      drain();
    end

    if (board.errors == 0 && board.verdicts.size() == 0)
      $display("tb_icmp_per_subnet_rate_filter passed");
    else
      $display("tb_icmp_per_subnet_rate_filter failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_icmp_per_subnet_rate_filter failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ipsrf_pkg.sv
hdl/ipsrf_if.sv
hdl/ipsrf_front.sv
hdl/ipsrf_back.sv
hdl/ipsrf_cfg.sv
hdl/icmp_per_subnet_rate_filter.sv
hdl/ipsrf_checker.sv
tb/tb_icmp_per_subnet_rate_filter.sv
